// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/bpdc_pkg.sv
// Package for the button press duration classifier: word types, event codes,
// register indexes and reset values. No dependencies.
package bpdc_pkg;

   // Event codes reported per poll
   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_DOWN   = 3'd1;
   localparam logic [2:0] EV_SHORT  = 3'd2;
   localparam logic [2:0] EV_LONG   = 3'd3;
   localparam logic [2:0] EV_VLONG  = 3'd4;
   localparam logic [2:0] EV_VVLONG = 3'd5;

   // Control register indexes
   localparam logic [2:0] REG_TOUCH_MODE   = 3'd0;
   localparam logic [2:0] REG_AUTO_CAL     = 3'd1;
   localparam logic [2:0] REG_LONG_MS      = 3'd2;
   localparam logic [2:0] REG_VLONG_MS     = 3'd3;
   localparam logic [2:0] REG_VVLONG_MS    = 3'd4;
   localparam logic [2:0] REG_TOUCH_LO_INI = 3'd5;
   localparam logic [2:0] REG_TOUCH_HI_INI = 3'd6;

   // Reset values
   localparam logic [15:0] RST_LONG_MS    = 16'd500;
   localparam logic [15:0] RST_VLONG_MS   = 16'd2000;
   localparam logic [15:0] RST_VVLONG_MS  = 16'd5000;
   localparam logic [15:0] RST_TOUCH_LO   = 16'hFFFF;
   localparam logic [15:0] RST_TOUCH_HI   = 16'h0000;

   // floor(t / 100) == (t * DIV100_MUL) >> DIV100_SHIFT for any 16-bit t
   localparam logic [16:0] DIV100_MUL   = 17'd83887;
   localparam int          DIV100_SHIFT = 23;

   typedef struct packed {
      logic        pin_level;
      logic [15:0] touch_sample;
      logic [31:0] time_ms;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] touch_low;
      logic [15:0] touch_high;
   } rsp_word_type;

   // Midpoint of two 16-bit bounds, truncated
   function automatic logic [15:0] midpoint(input logic [15:0] lo, input logic [15:0] hi);
      logic [16:0] sum;
      sum = {1'b0, lo} + {1'b0, hi};
      return sum[16:1];
   endfunction

endpackage

// File: hdl/button_press_duration_classifier.sv
// Button press duration classifier. One poll word is accepted per cycle with no
// bubbles while the response side is not stalled; its response passes through the input
// register, then the result register, and is offered from the result register. The
// rate is set by the update of the press and touch-tracking state (min/max, midpoint
// threshold, release bound, press time compare), which is done as each word leaves
// the input register.
// Control registers are written through the csr port, which is always ready;
// writing either touch bound register reloads the tracked bounds and threshold.
// Depends on bpdc_pkg.
module button_press_duration_classifier
   import bpdc_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   // poll words
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   // responses
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   // control registers
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   // Control registers
   logic        touch_mode_ff;
   logic        auto_cal_ff;
   logic [15:0] long_ms_ff, vlong_ms_ff, vvlong_ms_ff;
   logic [15:0] touch_lo_ini_ff, touch_hi_ini_ff;

   // Classifier state
   logic                 pressed_ff, pressed_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic [15:0]          tmin_ff, tmin_in;
   logic [15:0]          tmax_ff, tmax_in;
   logic [15:0]          thr_ff, thr_in;

   // Pipeline registers
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff, out_word_in;

   logic out_load;
   logic in_adv;
   logic csr_wr;
   logic reload;

   // Handshake
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_adv    = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign reload    = csr_wr && (csr_index == REG_TOUCH_LO_INI || csr_index == REG_TOUCH_HI_INI);

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         touch_mode_ff   <= 1'b0;
         auto_cal_ff     <= 1'b1;
         long_ms_ff      <= RST_LONG_MS;
         vlong_ms_ff     <= RST_VLONG_MS;
         vvlong_ms_ff    <= RST_VVLONG_MS;
         touch_lo_ini_ff <= RST_TOUCH_LO;
         touch_hi_ini_ff <= RST_TOUCH_HI;
      end else if (csr_wr) begin
         case (csr_index)
            REG_TOUCH_MODE:   touch_mode_ff   <= csr_data[0];
            REG_AUTO_CAL:     auto_cal_ff     <= csr_data[0];
            REG_LONG_MS:      long_ms_ff      <= csr_data;
            REG_VLONG_MS:     vlong_ms_ff     <= csr_data;
            REG_VVLONG_MS:    vvlong_ms_ff    <= csr_data;
            REG_TOUCH_LO_INI: touch_lo_ini_ff <= csr_data;
            REG_TOUCH_HI_INI: touch_hi_ini_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Per-poll classification
   logic [15:0]          tb;
   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] len;
   logic [2:0]           cls;
   logic [15:0]          tmin_nx, tmax_nx, thr_nx;
   logic [32:0]          div_prod;
   logic [9:0]           thr_div;
   logic [15:0]          rel_bound;
   logic [2:0]           ev;

   always_comb begin
      tb  = in_word_ff.touch_sample;
      now = TIME_BITS'(in_word_ff.time_ms);
      len = now - press_start_ff;

      // press length class, strict thresholds
      if (len > TIME_BITS'(vvlong_ms_ff))     cls = EV_VVLONG;
      else if (len > TIME_BITS'(vlong_ms_ff)) cls = EV_VLONG;
      else if (len > TIME_BITS'(long_ms_ff))  cls = EV_LONG;
      else                                    cls = EV_SHORT;

      // touch bound tracking
      tmin_nx = tmin_ff;
      tmax_nx = tmax_ff;
      if (tb < tmin_ff)      tmin_nx = tb;
      else if (tb > tmax_ff) tmax_nx = tb;
      thr_nx = auto_cal_ff ? midpoint(tmin_nx, tmax_nx) : thr_ff;

      // release floor: (thr / 100) * 60
      div_prod  = 33'(thr_nx) * 33'(DIV100_MUL);
      thr_div   = 10'(div_prod >> DIV100_SHIFT);
      rel_bound = 16'({thr_div, 6'd0}) - 16'({thr_div, 2'd0});

      ev             = EV_NONE;
      pressed_in     = pressed_ff;
      press_start_in = press_start_ff;
      tmin_in        = tmin_ff;
      tmax_in        = tmax_ff;
      thr_in         = thr_ff;

      if (!touch_mode_ff) begin
         if (!in_word_ff.pin_level && !pressed_ff) begin
            pressed_in     = 1'b1;
            press_start_in = now;
            ev             = EV_DOWN;
         end else if (in_word_ff.pin_level && pressed_ff) begin
            pressed_in = 1'b0;
            ev         = cls;
         end
      end else begin
         tmin_in = tmin_nx;
         tmax_in = tmax_nx;
         thr_in  = thr_nx;
         if (tb > thr_nx && !pressed_ff) begin
            pressed_in     = 1'b1;
            press_start_in = now;
            ev             = EV_DOWN;
         end else if (tb < thr_nx && pressed_ff && tb > rel_bound) begin
            pressed_in = 1'b0;
            ev         = cls;
         end
      end

      out_word_in.event_res  = ev;
      out_word_in.touch_low  = tmin_in;
      out_word_in.touch_high = tmax_in;
   end

   // State update as a word leaves the input register; reload on bound writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff     <= 1'b0;
         press_start_ff <= '0;
         tmin_ff        <= RST_TOUCH_LO;
         tmax_ff        <= RST_TOUCH_HI;
         thr_ff         <= midpoint(RST_TOUCH_LO, RST_TOUCH_HI);
      end else if (reload) begin
         // new init value comes from the write data for the register being written
         tmin_ff <= (csr_index == REG_TOUCH_LO_INI) ? csr_data : touch_lo_ini_ff;
         tmax_ff <= (csr_index == REG_TOUCH_HI_INI) ? csr_data : touch_hi_ini_ff;
         thr_ff  <= midpoint((csr_index == REG_TOUCH_LO_INI) ? csr_data : touch_lo_ini_ff,
                             (csr_index == REG_TOUCH_HI_INI) ? csr_data : touch_hi_ini_ff);
      end else if (in_adv) begin
         pressed_ff     <= pressed_in;
         press_start_ff <= press_start_in;
         tmin_ff        <= tmin_in;
         tmax_ff        <= tmax_in;
         thr_ff         <= thr_in;
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) in_valid_ff <= 1'b1;
         else if (in_adv)             in_valid_ff <= 1'b0;
         if (in_adv)        out_valid_ff <= 1'b1;
         else if (out_load) out_valid_ff <= 1'b0;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_word_ff <= req_data;
      if (in_adv) out_word_ff <= out_word_in;
   end

endmodule

// File: hdl/bpdc_checker.sv
// Port-level checks for the button press duration classifier, bound to the top.
// Depends on bpdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpdc_checker
   import bpdc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // a stalled response word stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp word dropped while stalled")
   // event codes stay within the defined set
   `ASSERT_CLK(a_ev_range, clock, reset, rsp_valid |-> rsp_data.event_res <= EV_VVLONG, "undefined event code")
   // input only backs up when a response is waiting and stalled
   `ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "req stalled with output free")
   // no response word right after reset
   `ASSERT_ALWAYS(a_rst_empty, clock, $past(reset) |-> !rsp_valid, "rsp valid after reset")

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/button_press_duration_classifier_tb.sv
// Self-checking testbench for the button press duration classifier.
// Depends on bpdc_pkg and the button_press_duration_classifier top level.
// A scoreboard predicts one response word per accepted poll word.
`timescale 1ns / 100ps

module button_press_duration_classifier_tb;
   import bpdc_pkg::*;

   // Register index that decodes to no register
   localparam logic [2:0] REG_NONE = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   button_press_duration_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the control registers
   logic        cfg_touch = 1'b0;
   logic        cfg_auto = 1'b1;
   logic [15:0] cfg_long = RST_LONG_MS;
   logic [15:0] cfg_vlong = RST_VLONG_MS;
   logic [15:0] cfg_vvlong = RST_VVLONG_MS;
   logic [15:0] cfg_lo_init = RST_TOUCH_LO;
   logic [15:0] cfg_hi_init = RST_TOUCH_HI;

   // Shadow copy of the press and touch tracking state
   logic        st_pressed = 1'b0;
   logic [31:0] st_start = '0;
   logic [15:0] st_min = RST_TOUCH_LO;
   logic [15:0] st_max = RST_TOUCH_HI;
   logic [15:0] st_thr = 16'd32767;

   rsp_word_type expected_rsp[$];
   int          fails = 0;
   logic        idle_en = 1'b1;
   logic [15:0] seen_thr = 16'd32767;
   logic [31:0] rnd_t = '0;
   logic        last_pin = 1'b1;

   initial begin
      forever #2 clock = ~clock;
   end

   // Truncated center of two 16-bit bounds
   function automatic logic [15:0] bounds_center(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16:1];
   endfunction

   // Event code for a release at time now
   function automatic logic [2:0] press_class(input logic [31:0] now);
      logic [31:0] len;
      len = now - st_start;
      if (len > {16'd0, cfg_vvlong}) return EV_VVLONG;
      if (len > {16'd0, cfg_vlong}) return EV_VLONG;
      if (len > {16'd0, cfg_long}) return EV_LONG;
      return EV_SHORT;
   endfunction

   function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         REG_TOUCH_MODE: cfg_touch = val[0];
         REG_AUTO_CAL:   cfg_auto = val[0];
         REG_LONG_MS:    cfg_long = val;
         REG_VLONG_MS:   cfg_vlong = val;
         REG_VVLONG_MS:  cfg_vvlong = val;
         REG_TOUCH_LO_INI, REG_TOUCH_HI_INI: begin
            if (idx == REG_TOUCH_LO_INI) cfg_lo_init = val;
            else cfg_hi_init = val;
            st_min = cfg_lo_init;
            st_max = cfg_hi_init;
            st_thr = bounds_center(st_min, st_max);
         end
         default: ;
      endcase
   endfunction

   // Advances the shadow state by one poll and returns its response word
   function automatic rsp_word_type next_response(input req_word_type w);
      rsp_word_type r;
      logic [2:0]   ev;
      logic [31:0]  floor_bound;
      ev = EV_NONE;
      if (!cfg_touch) begin
         if (!w.pin_level && !st_pressed) begin
            st_pressed = 1'b1;
            st_start = w.time_ms;
            ev = EV_DOWN;
         end else if (w.pin_level && st_pressed) begin
            st_pressed = 1'b0;
            ev = press_class(w.time_ms);
         end
      end else begin
         if (w.touch_sample < st_min) st_min = w.touch_sample;
         else if (w.touch_sample > st_max) st_max = w.touch_sample;
         if (cfg_auto) st_thr = bounds_center(st_min, st_max);
         floor_bound = ({16'd0, st_thr} / 32'd100) * 32'd60;
         if (w.touch_sample > st_thr && !st_pressed) begin
            st_pressed = 1'b1;
            st_start = w.time_ms;
            ev = EV_DOWN;
         end else if (w.touch_sample < st_thr && st_pressed &&
                      {16'd0, w.touch_sample} > floor_bound) begin
            st_pressed = 1'b0;
            ev = press_class(w.time_ms);
         end
      end
      r.event_res = ev;
      r.touch_low = st_min;
      r.touch_high = st_max;
      return r;
   endfunction

   // Scoreboard: register writes, accepted polls and responses at each edge
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_data);
         if (req_valid && !req_stall) expected_rsp.push_back(next_response(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected response word: ev=%0d lo=%h hi=%h",
                           rsp_data.event_res, rsp_data.touch_low, rsp_data.touch_high);
            end else begin
               exp_w = expected_rsp.pop_front();
               if (exp_w.event_res !== rsp_data.event_res ||
                   exp_w.touch_low !== rsp_data.touch_low ||
                   exp_w.touch_high !== rsp_data.touch_high) begin
                  fails++;
                  if (fails <= 10)
                     $display("response mismatch: exp ev=%0d lo=%h hi=%h, got ev=%0d lo=%h hi=%h",
                              exp_w.event_res, exp_w.touch_low, exp_w.touch_high,
                              rsp_data.event_res, rsp_data.touch_low, rsp_data.touch_high);
               end
            end
         end
      end
   end

   // Threshold as seen by the stimulus, settled at the falling edge
   always @(negedge clock) seen_thr <= st_thr;

   // Response side backpressure
   always @(negedge clock) rsp_stall <= idle_en && ($urandom_range(0, 99) < 31);

   task automatic send_poll(input logic pin, input logic [15:0] smp, input logic [31:0] t);
      req_word_type w;
      w.pin_level = pin;
      w.touch_sample = smp;
      w.time_ms = t;
      @(negedge clock);
      while (idle_en && $urandom_range(0, 99) < 31) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data = w;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off polls until every response is back and the pipeline is empty
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      settle();
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Pin mode at reset thresholds: boundaries, time wrap and time going backward
   task automatic test_pin_presses();
      send_poll(1'b1, 16'hFFFF, 32'd10);
      send_poll(1'b0, 16'h0000, 32'd100);
      send_poll(1'b0, 16'h1234, 32'd200);
      send_poll(1'b1, 16'hFFFF, 32'd600);
      send_poll(1'b0, 16'h0000, 32'd1000);
      send_poll(1'b1, 16'h8000, 32'd1501);
      send_poll(1'b0, 16'h7FFF, 32'd2000);
      send_poll(1'b1, 16'h0001, 32'd4001);
      send_poll(1'b0, 16'hFFFE, 32'd5000);
      send_poll(1'b1, 16'h5555, 32'd10001);
      send_poll(1'b0, 16'hAAAA, 32'hFFFF_FFF0);
      send_poll(1'b1, 16'h0F0F, 32'h0000_0010);
      send_poll(1'b0, 16'hF0F0, 32'd1000);
      send_poll(1'b1, 16'h00FF, 32'd999);
   endtask

   // Touch mode: tracking, release window edges, mode switch mid-press, bound reload
   task automatic test_touch_presses();
      write_reg(REG_TOUCH_MODE, 16'd1);
      send_poll(1'b0, 16'd0, 32'd0);
      send_poll(1'b1, 16'd65535, 32'd10);
      send_poll(1'b0, 16'd32767, 32'd20);
      send_poll(1'b1, 16'd19620, 32'd30);
      send_poll(1'b0, 16'd19621, 32'd700);
      send_poll(1'b1, 16'd40000, 32'd800);
      // press begun in touch mode, released on the pin
      write_reg(REG_TOUCH_MODE, 16'd0);
      send_poll(1'b1, 16'd0, 32'd900);
      write_reg(REG_TOUCH_MODE, 16'd1);
      write_reg(REG_AUTO_CAL, 16'd0);
      write_reg(REG_TOUCH_LO_INI, 16'd1000);
      write_reg(REG_TOUCH_HI_INI, 16'd3000);
      send_poll(1'b0, 16'd500, 32'd1000);
      send_poll(1'b1, 16'd5000, 32'd1100);
      send_poll(1'b0, 16'd1500, 32'd1200);
      write_reg(REG_NONE, 16'($urandom));
      write_reg(REG_AUTO_CAL, 16'd1);
      send_poll(1'b1, 16'd2500, 32'd1300);
   endtask

   // One random phase: fresh settings, then mostly press/release sequences
   task automatic random_phase(input int p, input int count);
      logic [15:0] lp, vp, vvp, lo_i, hi_i, smp, thr, bnd;
      logic [31:0] step;
      logic        pin;
      int          k;
      if (p == 0) begin
         lp = 16'd0; vp = 16'd0; vvp = 16'd0;
      end else if (p == 1) begin
         lp = 16'hFFFF; vp = 16'hFFFF; vvp = 16'hFFFF;
      end else begin
         lp = 16'($urandom_range(0, 1500));
         vp = 16'($urandom_range(0, 4000));
         vvp = 16'($urandom_range(0, 8000));
      end
      if (p == 2 || p == 3) begin
         lo_i = 16'd0; hi_i = 16'hFFFF;
      end else if (p == 1) begin
         lo_i = 16'hFFFF; hi_i = 16'd0;
      end else begin
         lo_i = 16'($urandom); hi_i = 16'($urandom);
      end
      write_reg(REG_TOUCH_MODE, 16'(p % 2));
      write_reg(REG_AUTO_CAL, 16'((p / 2) % 2));
      write_reg(REG_LONG_MS, lp);
      write_reg(REG_VLONG_MS, vp);
      write_reg(REG_VVLONG_MS, vvp);
      write_reg(REG_TOUCH_LO_INI, lo_i);
      write_reg(REG_TOUCH_HI_INI, hi_i);
      for (int i = 0; i < count; i++) begin
         // time step aimed at the press length thresholds
         k = $urandom_range(0, 99);
         if (k < 20) step = $urandom_range(0, 50);
         else if (k < 40) step = lp + $urandom_range(0, 4) - 2;
         else if (k < 55) step = vp + $urandom_range(0, 4) - 2;
         else if (k < 70) step = vvp + $urandom_range(0, 4) - 2;
         else if (k < 80) step = $urandom_range(0, 24000);
         else if (k < 88) step = 32'd0;
         else if (k < 95) step = $urandom - rnd_t;
         else step = 32'd0 - $urandom_range(1, 100);
         rnd_t = rnd_t + step;
         // pin mostly alternates
         pin = ($urandom_range(0, 99) < 80) ? ~last_pin : last_pin;
         last_pin = pin;
         // touch sample aimed above the threshold or into the release window
         thr = seen_thr;
         bnd = (thr / 16'd100) * 16'd60;
         k = $urandom_range(0, 99);
         if (k < 35) smp = (thr == 16'hFFFF) ? thr : 16'($urandom_range(thr + 1, 65535));
         else if (k < 70) smp = (thr > bnd + 1) ? 16'($urandom_range(bnd + 1, thr - 1))
                                                : 16'($urandom);
         else if (k < 80) smp = 16'($urandom_range(0, bnd));
         else if (k < 85) smp = thr;
         else smp = 16'($urandom);
         if (p == 5 && i == 40) settle();
         send_poll(pin, smp, rnd_t);
      end
   endtask

   task automatic test_random_sequences();
      for (int p = 0; p < 8; p++) begin
         idle_en = (p != 4);
         random_phase(p, 78);
      end
      idle_en = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_pin_presses();
      test_touch_presses();
      test_random_sequences();
      settle();
      repeat (8) @(posedge clock);
      if (fails == 0 && expected_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
